// ===== hdl/opb_pkg.sv =====
// Shared widths, register codes, result type and helpers for the opaque pixel bounding box.
package opb_pkg;

	// Widths fixed by the register map and the result fields.
	localparam int DIM_REG_W    = 11;
	localparam int STRIDE_W     = DIM_REG_W + 1;
	localparam int ANCHOR_W     = 16;
	localparam int EDGE_W       = 10;
	localparam int GROUND_W     = 17;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Default largest image dimension and queue depths.
	localparam int MAX_DIM_DEF  = 1024;
	localparam int IN_Q_DEPTH   = 4;
	localparam int OUT_Q_DEPTH  = 2;

	// Register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ANCHOR_Y     = 2'd2
	} opb_reg_t;

	// One result of a finished image.
	typedef struct packed {
		logic                       found;
		logic [EDGE_W-1:0]          left_edge;
		logic [EDGE_W-1:0]          right_edge;
		logic [EDGE_W-1:0]          top_edge;
		logic [EDGE_W-1:0]          bottom_edge;
		logic [EDGE_W-1:0]          center_x;
		logic [EDGE_W-1:0]          center_y;
		logic signed [GROUND_W-1:0] ground_y;
	} opb_result_t;

	// Largest dimension a register can actually select under a given limit.
	function automatic int opb_eff_dim(input int max_dim);
		int reg_max;
		reg_max = (1 << DIM_REG_W) - 1;
		return (max_dim > reg_max) ? reg_max : max_dim;
	endfunction

	// Column counter width: a column runs up to the padded stride minus one.
	function automatic int opb_col_w(input int max_dim);
		return $clog2(opb_eff_dim(max_dim) + 3);
	endfunction

	// Row counter width: a row runs up to the height minus one.
	function automatic int opb_row_w(input int max_dim);
		return $clog2(opb_eff_dim(max_dim));
	endfunction

endpackage

// ===== hdl/opb_fifo.sv =====
// Small register queue with first-word fall-through read.
module opb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = opb_pkg::IN_Q_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	import opb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/opb_front.sv =====
// Front part: raster position counters and per-byte classification.
module opb_front #(
	parameter int MAX_DIM = opb_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [opb_pkg::DIM_REG_W-1:0]  image_width,
	input  logic [opb_pkg::DIM_REG_W-1:0]  image_height,
	input  logic                           accept,
	input  logic [7:0]                     pixel_index,
	output logic [opb_pkg::opb_col_w(MAX_DIM) + opb_pkg::opb_row_w(MAX_DIM) + 1:0] entry
);
	import opb_pkg::*;

	localparam int EFF_DIM = opb_eff_dim(MAX_DIM);
	localparam int COL_W   = opb_col_w(MAX_DIM);
	localparam int ROW_W   = opb_row_w(MAX_DIM);

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [DIM_REG_W-1:0] w_eff;
	logic [DIM_REG_W-1:0] h_eff;
	logic [STRIDE_W-1:0]  stride;
	logic [STRIDE_W-1:0]  col_next;
	logic [STRIDE_W-1:0]  row_next;
	logic                 row_go_on;
	logic                 image_go_on;
	logic                 opaque;
	logic                 last_byte;

	// A zero dimension counts as one, an oversized one as the limit.
	always_comb begin
		priority if (image_width == '0) begin
			w_eff = DIM_REG_W'(1);
		end else if (image_width > DIM_REG_W'(EFF_DIM)) begin
			w_eff = DIM_REG_W'(EFF_DIM);
		end else begin
			w_eff = image_width;
		end
		priority if (image_height == '0) begin
			h_eff = DIM_REG_W'(1);
		end else if (image_height > DIM_REG_W'(EFF_DIM)) begin
			h_eff = DIM_REG_W'(EFF_DIM);
		end else begin
			h_eff = image_height;
		end
	end

	assign stride      = (STRIDE_W'(w_eff) + STRIDE_W'(3)) & ~STRIDE_W'(3);
	assign col_next    = STRIDE_W'(col_q) + STRIDE_W'(1);
	assign row_next    = STRIDE_W'(row_q) + STRIDE_W'(1);
	assign row_go_on   = (col_next < stride);
	assign image_go_on = (row_next < STRIDE_W'(h_eff));
	assign opaque      = (STRIDE_W'(col_q) < STRIDE_W'(w_eff)) && (pixel_index != 8'd0);
	assign last_byte   = !row_go_on && !image_go_on;

	assign entry = {last_byte, opaque, col_q, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_go_on) begin
				col_q <= col_next[COL_W-1:0];
			end else begin
				col_q <= '0;
				row_q <= image_go_on ? row_next[ROW_W-1:0] : '0;
			end
		end
	end

endmodule

// ===== hdl/opb_back.sv =====
// Back part: bounding box tracking and result formatting.
module opb_back #(
	parameter int MAX_DIM = opb_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                entry_valid,
	input  logic [opb_pkg::opb_col_w(MAX_DIM) + opb_pkg::opb_row_w(MAX_DIM) + 1:0] entry,
	output logic                                entry_pop,
	input  logic signed [opb_pkg::ANCHOR_W-1:0] anchor_y,
	input  logic                                res_full,
	output logic                                res_push,
	output opb_pkg::opb_result_t                res_data
);
	import opb_pkg::*;

	localparam int COL_W = opb_col_w(MAX_DIM);
	localparam int ROW_W = opb_row_w(MAX_DIM);

	logic             e_last;
	logic             e_opaque;
	logic [COL_W-1:0] e_col;
	logic [ROW_W-1:0] e_row;

	logic             seen_q;
	logic [COL_W-1:0] min_col_q, max_col_q;
	logic [ROW_W-1:0] min_row_q, max_row_q;

	logic             seen_n;
	logic [COL_W-1:0] min_col_n, max_col_n;
	logic [ROW_W-1:0] min_row_n, max_row_n;

	logic             valid_s1;
	logic             found_s1;
	logic [COL_W-1:0] min_col_s1, max_col_s1;
	logic [ROW_W-1:0] min_row_s1, max_row_s1;

	logic             s1_free;
	logic [COL_W:0]   sum_x;
	logic [ROW_W:0]   sum_y;
	logic [GROUND_W-1:0] ground;

	assign {e_last, e_opaque, e_col, e_row} = entry;

	always_comb begin
		seen_n    = seen_q;
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (e_opaque) begin
			seen_n = 1'b1;
			if (!seen_q) begin
				min_col_n = e_col;
				max_col_n = e_col;
				min_row_n = e_row;
				max_row_n = e_row;
			end else begin
				if (e_col < min_col_q) min_col_n = e_col;
				if (e_col > max_col_q) max_col_n = e_col;
				if (e_row < min_row_q) min_row_n = e_row;
				if (e_row > max_row_q) max_row_n = e_row;
			end
		end
	end

	assign res_push  = valid_s1 && !res_full;
	assign s1_free   = !valid_s1 || !res_full;
	assign entry_pop = entry_valid && (!e_last || s1_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (entry_pop) begin
				if (e_last) begin
					seen_q    <= 1'b0;
					min_col_q <= '0;
					max_col_q <= '0;
					min_row_q <= '0;
					max_row_q <= '0;
				end else begin
					seen_q    <= seen_n;
					min_col_q <= min_col_n;
					max_col_q <= max_col_n;
					min_row_q <= min_row_n;
					max_row_q <= max_row_n;
				end
			end
			if (entry_pop && e_last) begin
				valid_s1 <= 1'b1;
			end else if (res_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop && e_last) begin
			found_s1   <= seen_n;
			min_col_s1 <= min_col_n;
			max_col_s1 <= max_col_n;
			min_row_s1 <= min_row_n;
			max_row_s1 <= max_row_n;
		end
	end

	assign sum_x  = (COL_W+1)'(min_col_s1) + (COL_W+1)'(max_col_s1) + (COL_W+1)'(1);
	assign sum_y  = (ROW_W+1)'(min_row_s1) + (ROW_W+1)'(max_row_s1) + (ROW_W+1)'(1);
	assign ground = {{(GROUND_W-ROW_W){1'b0}}, max_row_s1}
		- {{(GROUND_W-ANCHOR_W){anchor_y[ANCHOR_W-1]}}, anchor_y};

	// An image with no opaque pixel reports all fields as zero.
	always_comb begin
		res_data = '0;
		if (found_s1) begin
			res_data.found       = 1'b1;
			res_data.left_edge   = EDGE_W'(min_col_s1);
			res_data.right_edge  = EDGE_W'(max_col_s1);
			res_data.top_edge    = EDGE_W'(min_row_s1);
			res_data.bottom_edge = EDGE_W'(max_row_s1);
			res_data.center_x    = EDGE_W'(sum_x[COL_W:1]);
			res_data.center_y    = EDGE_W'(sum_y[ROW_W:1]);
			res_data.ground_y    = ground;
		end
	end

endmodule

// ===== hdl/opaque_pixel_bounding_box.sv =====
// Top level of the opaque pixel bounding box: register port, front, queues and back.
//
//   Channel   Signals                                  Direction  Moves
//   config    psel penable pwrite paddr pwdata prdata  in/out     register writes and reads
//   pixels    push full pixel_index                    in         one palette byte per request
//   results   pop empty found ... ground_y             out        one box per finished image
//
// The block takes one pixel byte per clock cycle while full is low, padding
// bytes included. The front counts column and row and tags each byte as
// opaque or not and as the last byte of the image; the back folds tagged
// bytes into the box one per cycle unless it has stopped. The result of an
// image passes the pixel queue, the format stage and the result queue before
// it can be popped. Reset clears all counters, the box and both queues at
// once and loads width 1, height 1 and anchor 0; no clearing pass follows.
// While results are not popped, the result queue, the format stage and then
// the four-entry pixel queue fill; full rises only when the back has stopped
// on a last byte with nowhere to put its result.
module opaque_pixel_bounding_box #(
	parameter int MAX_DIM = opb_pkg::MAX_DIM_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [opb_pkg::PADDR_W-1:0]          paddr,
	input  logic [opb_pkg::PDATA_W-1:0]          pwdata,
	output logic [opb_pkg::PDATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 push,
	output logic                                 full,
	input  logic [7:0]                           pixel_index,
	input  logic                                 pop,
	output logic                                 empty,
	output logic                                 found,
	output logic [opb_pkg::EDGE_W-1:0]           left_edge,
	output logic [opb_pkg::EDGE_W-1:0]           right_edge,
	output logic [opb_pkg::EDGE_W-1:0]           top_edge,
	output logic [opb_pkg::EDGE_W-1:0]           bottom_edge,
	output logic [opb_pkg::EDGE_W-1:0]           center_x,
	output logic [opb_pkg::EDGE_W-1:0]           center_y,
	output logic signed [opb_pkg::GROUND_W-1:0]  ground_y
);
	import opb_pkg::*;

	localparam int ENTRY_W = opb_col_w(MAX_DIM) + opb_row_w(MAX_DIM) + 2;
	localparam int RES_W   = $bits(opb_result_t);

	logic [DIM_REG_W-1:0]       width_q;
	logic [DIM_REG_W-1:0]       height_q;
	logic signed [ANCHOR_W-1:0] anchor_q;
	logic                       cfg_wr;

	logic                       accept;
	logic [ENTRY_W-1:0]         entry_in;
	logic [ENTRY_W-1:0]         entry_out;
	logic                       entry_empty;
	logic                       entry_pop;

	logic                       res_full;
	logic                       res_push;
	opb_result_t                res_in;
	logic [RES_W-1:0]           res_out;
	opb_result_t                res_head;

	// Register port: a write lands on the access cycle; reads are always ready.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_REG_W'(1);
			height_q <= DIM_REG_W'(1);
			anchor_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[DIM_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_REG_W-1:0];
				REG_ANCHOR_Y:     anchor_q <= pwdata[ANCHOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
			REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
			REG_ANCHOR_Y:     prdata = {{(PDATA_W-ANCHOR_W){1'b0}}, anchor_q};
			default:          prdata = '0;
		endcase
	end

	// A pixel request is taken whenever the pixel queue has room.
	assign accept = push && !full;

	opb_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (width_q),
		.image_height(height_q),
		.accept      (accept),
		.pixel_index (pixel_index),
		.entry       (entry_in)
	);

	opb_fifo #(
		.WIDTH(ENTRY_W),
		.DEPTH(IN_Q_DEPTH)
	) u_pix_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_data(entry_in),
		.rd_en  (entry_pop),
		.rd_data(entry_out),
		.full   (full),
		.empty  (entry_empty)
	);

	opb_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_valid(!entry_empty),
		.entry      (entry_out),
		.entry_pop  (entry_pop),
		.anchor_y   (anchor_q),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	opb_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUT_Q_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.rd_en  (pop),
		.rd_data(res_out),
		.full   (res_full),
		.empty  (empty)
	);

	// The oldest result stays on the result ports until it is popped.
	assign res_head    = opb_result_t'(res_out);
	assign found       = res_head.found;
	assign left_edge   = res_head.left_edge;
	assign right_edge  = res_head.right_edge;
	assign top_edge    = res_head.top_edge;
	assign bottom_edge = res_head.bottom_edge;
	assign center_x    = res_head.center_x;
	assign center_y    = res_head.center_y;
	assign ground_y    = res_head.ground_y;

endmodule

// ===== hdl/opb_checker.sv =====
// Port-level checks for the opaque pixel bounding box, bound to the top level.
module opb_checker #(
	parameter int MAX_DIM = opb_pkg::MAX_DIM_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                full,
	input logic                                pop,
	input logic                                empty,
	input logic                                found,
	input logic [opb_pkg::EDGE_W-1:0]          left_edge,
	input logic [opb_pkg::EDGE_W-1:0]          right_edge,
	input logic [opb_pkg::EDGE_W-1:0]          top_edge,
	input logic [opb_pkg::EDGE_W-1:0]          bottom_edge,
	input logic [opb_pkg::EDGE_W-1:0]          center_x,
	input logic [opb_pkg::EDGE_W-1:0]          center_y,
	input logic signed [opb_pkg::GROUND_W-1:0] ground_y
);
	import opb_pkg::*;

	// Both queues come out of reset empty.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	// An image without opaque pixels reports nothing but zeros.
	a_empty_image_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (left_edge == '0 && right_edge == '0 && top_edge == '0
			&& bottom_edge == '0 && center_x == '0 && center_y == '0
			&& ground_y == '0))
		else $error("empty image result carries nonzero fields");

	// Edges are ordered and the centers lie where rounding up puts them.
	a_box_shape: assert property (@(posedge clk) disable iff (!arst_n)
		((MAX_DIM <= (1 << EDGE_W)) && !empty && found) |->
			(left_edge <= right_edge && top_edge <= bottom_edge
			&& center_x == EDGE_W'(((EDGE_W+1)'(left_edge) + (EDGE_W+1)'(right_edge)
				+ (EDGE_W+1)'(1)) >> 1)
			&& center_y == EDGE_W'(((EDGE_W+1)'(top_edge) + (EDGE_W+1)'(bottom_edge)
				+ (EDGE_W+1)'(1)) >> 1)))
		else $error("bounding box result is inconsistent");

	// A waiting result keeps its found flag, left and bottom edges and ground value until it is popped.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(found) && $stable(left_edge)
			&& $stable(bottom_edge) && $stable(ground_y)))
		else $error("waiting result changed before pop");

endmodule

bind opaque_pixel_bounding_box opb_checker #(
	.MAX_DIM(MAX_DIM)
) u_opb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.pop        (pop),
	.empty      (empty),
	.found      (found),
	.left_edge  (left_edge),
	.right_edge (right_edge),
	.top_edge   (top_edge),
	.bottom_edge(bottom_edge),
	.center_x   (center_x),
	.center_y   (center_y),
	.ground_y   (ground_y)
);
